// ===== src/ffra_pkg.sv =====
// ffra_pkg: shared types, codes and sizes of the first-fit region allocator
// depends on nothing; imported by every module under src
package ffra_pkg;

	// table and address sizes
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_W      = 32;
	localparam int PAGE_BYTES  = 4096;
	localparam int CFG_IDX_W   = 1;

	// configuration register reset values
	localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] HEAP_END_RST   = 32'h0040_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

	// request kinds
	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_ALIGN = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// what a table scan looks for
	typedef enum logic [1:0] {
		SM_GAP   = 2'd0,
		SM_INS   = 2'd1,
		SM_MATCH = 2'd2
	} scan_mode_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GAP,
		S_INS,
		S_MATCH,
		S_MOVE_INS,
		S_MOVE_FREE,
		S_RESP
	} state_t;

	// one table entry
	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
	} entry_t;

	// commands from the controller
	typedef struct packed {
		logic       load;
		logic       scan;
		scan_mode_t mode;
		logic       mv_step;
		logic       write_new;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       set_res;
		logic       res_grant;
		status_t    res_status;
		logic       out_load;
	} ctrl_cmd_t;

	// status from the datapath
	typedef struct packed {
		logic hit;
		logic exhaust;
		logic fits;
		logic full;
		logic mv_done;
	} dp_status_t;

endpackage

// ===== src/first_fit_region_allocator.sv =====
// first_fit_region_allocator: top level, output register and unit hookup
// depends on ffra_pkg, ffra_ctrl and ffra_datapath
//
//  channel  signals                                        direction
//  request  in_valid/in_ready, kind, request_size,
//           release_address                                in
//  result   out_valid/out_ready, granted_address, status   out
//  config   cfg_write, cfg_index, cfg_data                 in, write only
//
// one request at a time; the table memory is read once per cycle, so a scan
// reads the stored regions one by one and a shift moves one entry at a time.
// allocate: gap scan, then insert scan and shift; free: match scan, then shift;
// kind 3 goes to the output register with no scan.
// reset empties the table at once (entry count cleared) and restores the window.
// a stalled result holds in the output register; the next request is taken meanwhile.
module first_fit_region_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [31:0]                    request_size,
	input  logic [31:0]                    release_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    granted_address,
	output logic [1:0]                     status,
	input  logic                           cfg_write,
	input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import ffra_pkg::*;

	ctrl_cmd_t   cmd;
	dp_status_t  stat;
	logic [31:0] res_addr;
	status_t     res_status;
	logic        out_free;
	logic        out_valid_q;
	logic [31:0] granted_q;
	status_t     status_q;

	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffra_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (kind),
		.request_size    (request_size),
		.release_address (release_address),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.res_addr_q      (res_addr),
		.res_status_q    (res_status)
	);

	// output register, free once its transfer completes
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			granted_q <= res_addr;
			status_q  <= res_status;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = granted_q;
	assign status          = status_q;

endmodule

// ===== src/ffra_datapath.sv =====
// ffra_datapath: region table memory, scan and move engines, heap window registers
// depends on ffra_pkg; driven by ffra_ctrl through ctrl_cmd_t
module ffra_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffra_pkg::ctrl_cmd_t           cmd,
	output ffra_pkg::dp_status_t          stat,
	input  logic [1:0]                    kind,
	input  logic [31:0]                   request_size,
	input  logic [31:0]                   release_address,
	input  logic                          cfg_write,
	input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic [31:0]                   res_addr_q,
	output ffra_pkg::status_t             res_status_q
);
	import ffra_pkg::*;

	entry_t            mem_q [TABLE_DEPTH];

	logic [ADDR_W-1:0] heap_start_q;
	logic [ADDR_W-1:0] heap_end_q;
	kind_t             kind_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] rel_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] last_q;
	logic [CNT_W-1:0]  scan_idx_q;
	logic              scan_vld_s1;
	entry_t            rd_s1;
	logic [ADDR_W-1:0] grant_q;
	logic [ADDR_W-1:0] grant_end_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  mv_src_q;
	logic [CNT_W-1:0]  mv_left_q;
	logic              mv_up_q;
	logic              mv_vld_s1;
	logic [IDX_W-1:0]  mv_dst_s1;

	logic              aligned;
	logic [ADDR_W:0]   pos33;
	logic [ADDR_W:0]   lim33;
	logic [ADDR_W:0]   diff33;
	logic              order_ok;
	logic              fits;
	logic              crit;
	logic              hit;
	logic              exhaust;
	logic [CNT_W-1:0]  k_next;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	// gap check: running position, optionally page rounded in 33 bits
	assign aligned  = (kind_q == KIND_ALIGN);
	assign pos33    = aligned
		? (({1'b0, last_q} + (ADDR_W+1)'(PAGE_BYTES - 1)) & ~(ADDR_W+1)'(PAGE_BYTES - 1))
		: {1'b0, last_q};
	assign lim33    = scan_vld_s1 ? {1'b0, rd_s1.start_addr} : {1'b0, heap_end_q};
	assign diff33   = lim33 - pos33;
	assign order_ok = aligned ? (pos33 < lim33) : (pos33 <= lim33);
	assign fits     = order_ok && (diff33 >= {1'b0, size_q});

	// scan criterion per mode
	always_comb begin
		case (cmd.mode)
			SM_GAP:   crit = fits;
			SM_INS:   crit = (rd_s1.start_addr > grant_q);
			SM_MATCH: crit = (rd_s1.start_addr == rel_q);
			default:  crit = 1'b0;
		endcase
	end

	assign hit     = scan_vld_s1 && crit;
	assign exhaust = !scan_vld_s1 && (scan_idx_q >= count_q);
	assign k_next  = hit ? (scan_idx_q - CNT_W'(1)) : count_q;

	assign stat.hit     = hit;
	assign stat.exhaust = exhaust;
	assign stat.fits    = fits;
	assign stat.full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign stat.mv_done = (mv_left_q == '0) && !mv_vld_s1;

	// memory port selection
	assign rd_addr = cmd.mv_step ? mv_src_q[IDX_W-1:0] : scan_idx_q[IDX_W-1:0];
	assign wr_en   = cmd.write_new || mv_vld_s1;
	assign wr_addr = cmd.write_new ? k_q[IDX_W-1:0] : mv_dst_s1;
	assign wr_data = cmd.write_new ? entry_t'{start_addr: grant_q, end_addr: grant_end_q} : rd_s1;

	// region table memory
	always_ff @(posedge clk) begin
		rd_s1 <= mem_q[rd_addr];
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// heap window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= HEAP_START_RST;
			heap_end_q   <= HEAP_END_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEAP_START: heap_start_q <= cfg_data;
				CFG_HEAP_END:   heap_end_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	// request capture, result and found-position registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			size_q <= request_size;
			rel_q  <= release_address;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= cmd.res_grant ? grant_q : '0;
		end
		if (cmd.scan && (hit || exhaust)) begin
			k_q <= k_next;
			if ((cmd.mode == SM_GAP) && (hit || fits)) begin
				grant_q     <= pos33[ADDR_W-1:0];
				grant_end_q <= pos33[ADDR_W-1:0] + size_q;
			end
		end
	end

	// running position of the gap scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= heap_start_q;
		end else if (cmd.scan && scan_vld_s1 && !hit) begin
			last_q <= rd_s1.end_addr;
		end
	end

	// scan engine: one read issued per cycle, checked in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (cmd.scan) begin
			if (hit || exhaust) begin
				scan_idx_q  <= '0;
				scan_vld_s1 <= 1'b0;
			end else if (scan_idx_q < count_q) begin
				scan_idx_q  <= scan_idx_q + CNT_W'(1);
				scan_vld_s1 <= 1'b1;
			end else begin
				scan_vld_s1 <= 1'b0;
			end
		end
	end

	// move engine: read source, write it one slot over in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_src_q  <= '0;
			mv_left_q <= '0;
			mv_up_q   <= 1'b0;
			mv_vld_s1 <= 1'b0;
		end else if (cmd.scan && (hit || exhaust)) begin
			if (cmd.mode == SM_INS) begin
				mv_src_q  <= count_q - CNT_W'(1);
				mv_left_q <= count_q - k_next;
				mv_up_q   <= 1'b0;
			end else if (cmd.mode == SM_MATCH) begin
				mv_src_q  <= k_next + CNT_W'(1);
				mv_left_q <= count_q - k_next - CNT_W'(1);
				mv_up_q   <= 1'b1;
			end
		end else if (cmd.mv_step) begin
			if (mv_left_q != '0) begin
				mv_vld_s1 <= 1'b1;
				mv_left_q <= mv_left_q - CNT_W'(1);
				mv_src_q  <= mv_up_q ? (mv_src_q + CNT_W'(1)) : (mv_src_q - CNT_W'(1));
			end else begin
				mv_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mv_step && (mv_left_q != '0)) begin
			mv_dst_s1 <= mv_up_q ? (mv_src_q[IDX_W-1:0] - IDX_W'(1))
			                     : (mv_src_q[IDX_W-1:0] + IDX_W'(1));
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== src/ffra_ctrl.sv =====
// ffra_ctrl: request sequencer of the region allocator
// depends on ffra_pkg; commands ffra_datapath, reads its dp_status_t
module ffra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic                 out_free,
	input  ffra_pkg::dp_status_t stat,
	output ffra_pkg::ctrl_cmd_t  cmd
);
	import ffra_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.mode       = SM_GAP;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (kind_t'(kind))
						KIND_ALLOC, KIND_ALIGN: state_d = S_GAP;
						KIND_FREE:              state_d = S_MATCH;
						default: begin
							cmd.set_res = 1'b1;
							state_d     = S_RESP;
						end
					endcase
				end
			end
			S_GAP: begin
				cmd.scan = 1'b1;
				cmd.mode = SM_GAP;
				if (stat.hit || (stat.exhaust && stat.fits)) begin
					if (stat.full) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_FULL;
						state_d        = S_RESP;
					end else begin
						state_d = S_INS;
					end
				end else if (stat.exhaust) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NO_SPACE;
					state_d        = S_RESP;
				end
			end
			S_INS: begin
				cmd.scan = 1'b1;
				cmd.mode = SM_INS;
				if (stat.hit || stat.exhaust) begin
					state_d = S_MOVE_INS;
				end
			end
			S_MATCH: begin
				cmd.scan = 1'b1;
				cmd.mode = SM_MATCH;
				if (stat.hit) begin
					state_d = S_MOVE_FREE;
				end else if (stat.exhaust) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_RESP;
				end
			end
			S_MOVE_INS: begin
				cmd.mv_step = 1'b1;
				if (stat.mv_done) begin
					cmd.write_new = 1'b1;
					cmd.cnt_inc   = 1'b1;
					cmd.set_res   = 1'b1;
					cmd.res_grant = 1'b1;
					state_d       = S_RESP;
				end
			end
			S_MOVE_FREE: begin
				cmd.mv_step = 1'b1;
				if (stat.mv_done) begin
					cmd.cnt_dec = 1'b1;
					cmd.set_res = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== test/first_fit_region_allocator_test.sv =====
// testbench for first_fit_region_allocator: random and directed requests with a scoreboard
// depends on ffra_pkg and the first_fit_region_allocator rtl under src
module first_fit_region_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffra_pkg::*;

	// tracks the region table and the heap window, predicts one result per request
	class alloc_scoreboard;
		logic [31:0] heap_lo;
		logic [31:0] heap_hi;
		logic [31:0] reg_start [TABLE_DEPTH];
		logic [31:0] reg_end [TABLE_DEPTH];
		int          used;
		logic [31:0] want_addr [$];
		status_t     want_status [$];
		int          errors;
		int          checked;
		int          tally [4];

		function new();
			heap_lo = HEAP_START_RST;
			heap_hi = HEAP_END_RST;
			used    = 0;
			errors  = 0;
			checked = 0;
			foreach (tally[i]) tally[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == CFG_HEAP_START) heap_lo = value;
			else if (idx == CFG_HEAP_END) heap_hi = value;
		endfunction

		function int pending();
			return want_addr.size();
		endfunction

		// a start address currently held in the table, or noise when it is empty
		function logic [31:0] any_start();
			if (used == 0) return $urandom;
			return reg_start[$urandom_range(0, used - 1)];
		endfunction

		function logic [63:0] page_round(logic [63:0] p);
			return (p + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
		endfunction

		// gap [p, limit) checked against size, aligned starts must stay below the limit
		function bit gap_ok(logic [63:0] p, logic [63:0] limit, logic [63:0] size,
				bit aligned);
			if (aligned) begin
				if (p > 64'hFFFF_FFFF || p >= limit) return 1'b0;
			end else if (p > limit) begin
				return 1'b0;
			end
			return ((limit > p) ? limit - p : 64'd0) >= size;
		endfunction

		// first-fit search, then sorted insert
		function void predict_alloc(logic [31:0] size, bit aligned,
				output logic [31:0] addr, output status_t st);
			logic [63:0] last;
			logic [63:0] pos;
			bit          found;
			int          i;
			int          at;
			last  = {32'd0, heap_lo};
			pos   = 64'd0;
			found = 1'b0;
			i     = 0;
			while (i < used && !found) begin
				pos = aligned ? page_round(last) : last;
				if (gap_ok(pos, {32'd0, reg_start[i]}, {32'd0, size}, aligned)) begin
					found = 1'b1;
				end else begin
					last = {32'd0, reg_end[i]};
					i++;
				end
			end
			addr = 32'd0;
			if (!found) begin
				pos = aligned ? page_round(last) : last;
				if (!gap_ok(pos, {32'd0, heap_hi}, {32'd0, size}, aligned)) begin
					st = ST_NO_SPACE;
					return;
				end
			end
			if (used >= TABLE_DEPTH) begin
				st = ST_FULL;
				return;
			end
			at = 0;
			while (at < used && reg_start[at] <= pos[31:0]) at++;
			for (i = used; i > at; i--) begin
				reg_start[i] = reg_start[i - 1];
				reg_end[i]   = reg_end[i - 1];
			end
			reg_start[at] = pos[31:0];
			reg_end[at]   = pos[31:0] + size;
			used++;
			addr = pos[31:0];
			st   = ST_OK;
		endfunction

		// first entry with a matching start is removed
		function void predict_free(logic [31:0] where, output logic [31:0] addr,
				output status_t st);
			int e;
			int i;
			addr = 32'd0;
			e    = 0;
			while (e < used && reg_start[e] != where) e++;
			if (e >= used) begin
				st = ST_NOT_FOUND;
				return;
			end
			for (i = e; i + 1 < used; i++) begin
				reg_start[i] = reg_start[i + 1];
				reg_end[i]   = reg_end[i + 1];
			end
			used--;
			st = ST_OK;
		endfunction

		// called on every accepted request transfer
		function void note_request(kind_t k, logic [31:0] size, logic [31:0] where);
			logic [31:0] addr;
			status_t     st;
			case (k)
				KIND_ALLOC: predict_alloc(size, 1'b0, addr, st);
				KIND_ALIGN: predict_alloc(size, 1'b1, addr, st);
				KIND_FREE:  predict_free(where, addr, st);
				default: begin
					addr = 32'd0;
					st   = ST_OK;
				end
			endcase
			tally[st]++;
			want_addr.push_back(addr);
			want_status.push_back(st);
		endfunction

		// called on every accepted result transfer
		function void check_result(logic [31:0] addr, logic [1:0] st);
			logic [31:0] exp_addr;
			status_t     exp_st;
			if (want_addr.size() == 0) begin
				$error("unexpected result: granted_address %h status %0d", addr, st);
				errors++;
				return;
			end
			exp_addr = want_addr.pop_front();
			exp_st   = want_status.pop_front();
			checked++;
			if (addr !== exp_addr) begin
				$error("granted_address: expected %h, got %h", exp_addr, addr);
				errors++;
			end
			if (st !== exp_st) begin
				$error("status: expected %0d, got %0d", exp_st, st);
				errors++;
			end
		endfunction
	endclass

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 in_valid        = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind            = 2'd0;
	logic [31:0]          request_size    = 32'd0;
	logic [31:0]          release_address = 32'd0;
	logic                 out_valid;
	logic                 out_ready       = 1'b0;
	logic [31:0]          granted_address;
	logic [1:0]           status;
	logic                 cfg_write       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index       = '0;
	logic [31:0]          cfg_data        = 32'd0;

	alloc_scoreboard sb = new();
	int burst_left = 0;
	int windows    = 1;
	int stall_left = 0;
	bit stall_on   = 1'b0;

	first_fit_region_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.request_size    (request_size),
		.release_address (release_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted_address (granted_address),
		.status          (status),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// clock
	always #10 clk = ~clk;

	// receiver stalls in stretches of its own
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_on   = ($urandom_range(0, 3) == 0);
			stall_left = stall_on ? $urandom_range(1, 15) : $urandom_range(1, 40);
		end
		stall_left--;
		out_ready <= !stall_on;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(granted_address, status);
	end

	// sender bursts with random gaps, some long enough to find the block idle
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(100, 300);
				default: gap = $urandom_range(1, 12);
			endcase
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	// one request transfer
	task automatic send(kind_t k, logic [31:0] size, logic [31:0] where);
		pace();
		@(negedge clk);
		in_valid        <= 1'b1;
		kind            <= k;
		request_size    <= size;
		release_address <= where;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(k, size, where);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_window(logic [31:0] lo, logic [31:0] hi);
		settle();
		write_cfg(CFG_HEAP_START, lo);
		write_cfg(CFG_HEAP_END, hi);
		windows++;
	endtask

	// mostly small sizes, some large, some full width
	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			7:       return $urandom_range(8193, 32'h0010_0000);
			8:       return $urandom;
			9:       return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 8192);
		endcase
	endfunction

	// random mix of allocates, frees of held regions, stray frees and no-ops
	task automatic run_mix(int n, int alloc_pct);
		int          r;
		kind_t       k;
		logic [31:0] size;
		logic [31:0] where;
		repeat (n) begin
			r     = $urandom_range(0, 99);
			size  = $urandom;
			where = $urandom;
			if (r < alloc_pct) begin
				k    = ($urandom_range(0, 2) == 0) ? KIND_ALIGN : KIND_ALLOC;
				size = pick_size();
			end else if (r < 96) begin
				k = KIND_FREE;
				case ($urandom_range(0, 5))
					0:       where = $urandom;
					1:       where = sb.any_start() + 32'd1;
					default: where = sb.any_start();
				endcase
			end else begin
				k = KIND_NOP;
			end
			send(k, size, where);
		end
	endtask

	// free every held region
	task automatic drain();
		while (sb.used > 0)
			send(KIND_FREE, $urandom, sb.any_start());
	endtask

	// run limit
	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, zero sizes, duplicates, misses, extremes
		send(KIND_FREE, 32'd0, 32'd0);
		send(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(KIND_ALLOC, 32'd0, 32'd0);
		send(KIND_ALLOC, 32'd0, 32'd0);
		send(KIND_FREE, 32'd0, HEAP_START_RST);
		send(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send(KIND_ALIGN, 32'd1, 32'd0);
		send(KIND_ALLOC, 32'd1, 32'd0);
		send(KIND_ALIGN, 32'd4096, 32'd0);
		send(KIND_ALLOC, 32'd4095, 32'd0);
		send(KIND_ALLOC, 32'h0030_0000, 32'd0);
		send(KIND_FREE, 32'd0, sb.any_start());
		send(KIND_ALLOC, 32'd1, 32'd0);
		send(KIND_ALIGN, 32'd0, 32'd0);
		send(KIND_FREE, 32'd0, 32'hFFFF_FFFF);
		send(KIND_ALLOC, 32'h002F_0000, 32'd0);
		send(KIND_FREE, 32'd0, HEAP_START_RST);
		send(KIND_NOP, 32'd0, 32'd0);
		send(KIND_ALIGN, 32'hFFFF_FFFF, 32'd0);
		send(KIND_FREE, 32'd0, HEAP_START_RST);

		// reset window
		run_mix(150, 60);

		// widest window
		set_window(32'd1, 32'hFFFF_FFFF);
		send(KIND_ALLOC, 32'hFFFF_FFFE, 32'd0);
		run_mix(120, 60);

		// window large enough to fill the table
		set_window(32'h0000_1000, 32'h0100_0000);
		run_mix(200, 85);
		drain();

		// window at the top of the address space: aligned starts round past 2^32
		set_window(32'hFFFF_F001, 32'hFFFF_FFFF);
		send(KIND_ALIGN, 32'd1, 32'd0);
		send(KIND_ALLOC, 32'd1, 32'd0);
		send(KIND_ALIGN, 32'd0, 32'd0);
		send(KIND_ALLOC, 32'd0, 32'd0);
		run_mix(60, 60);

		// inverted window
		set_window(32'h8000_0000, 32'h0000_1000);
		run_mix(60, 60);

		// back to the reset window
		set_window(HEAP_START_RST, HEAP_END_RST);
		run_mix(150, 55);

		settle();
		repeat (200) @(posedge clk);
		$display("%0d results checked over %0d heap windows", sb.checked, windows);
		$display("outcomes: %0d ok, %0d no space, %0d table full, %0d not found",
			sb.tally[ST_OK], sb.tally[ST_NO_SPACE], sb.tally[ST_FULL],
			sb.tally[ST_NOT_FOUND]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
